// File: hw/rtl/ccf_pkg.sv
// Shared types, constants and coefficient helper for the cubic curve flattener.
package ccf_pkg;

  localparam int CoordW           = 18;  // Q14.4 coordinate
  localparam int CoefW            = 27;  // power-basis coefficient, scaled by 6
  localparam int AccW             = 28;  // acceleration bound magnitude
  localparam int SumW             = 44;  // Horner sum, 16 extra fraction bits
  localparam int HornerW          = 62;  // split product accumulator
  localparam int MulW             = 28;  // shared multiplier operand width
  localparam int TW               = 17;  // parameter t, Q1.16 up to 1.0
  localparam int TOne             = 65536;
  localparam int QuotW            = 27;  // rounding quotient operand
  localparam int Div3Mag          = 44739243;  // (2^27 + 1) / 3
  localparam int Div3Bias         = 50331648;  // 3 * 2^24, keeps operand positive
  localparam int MaxResultsDef    = 64;
  localparam int CoordFracBitsDef = 4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COEF,
    S_ACCEL,
    S_DECIDE,
    S_DIV,
    S_SQRT,
    S_HLO,
    S_HHI,
    S_RND,
    S_DIV3,
    S_SAT,
    S_EMIT
  } ccf_state_e;

  typedef struct packed {
    logic signed [CoefW-1:0] c3;
    logic signed [CoefW-1:0] c2;
    logic signed [CoefW-1:0] c1;
    logic signed [CoefW-1:0] c0;
  } coef_set_t;

  function automatic logic signed [CoefW-1:0] times6(input logic signed [CoefW-1:0] v);
    times6 = (v <<< 2) + (v <<< 1);
  endfunction

  function automatic logic signed [CoefW-1:0] times3(input logic signed [CoefW-1:0] v);
    times3 = (v <<< 1) + v;
  endfunction

  // Power-basis coefficients, all scaled by 6 so the spline needs no division.
  function automatic coef_set_t make_coefs(input logic spline,
                                           input logic signed [CoordW-1:0] q0,
                                           input logic signed [CoordW-1:0] q1,
                                           input logic signed [CoordW-1:0] q2,
                                           input logic signed [CoordW-1:0] q3);
    coef_set_t c;
    logic signed [CoefW-1:0] a0, a1, a2, a3, cub, quad;
    a0   = CoefW'(q0);
    a1   = CoefW'(q1);
    a2   = CoefW'(q2);
    a3   = CoefW'(q3);
    cub  = a3 - a0 + times3(a1 - a2);
    quad = times3(a0 - (a1 <<< 1) + a2);
    if (spline) begin
      c.c3 = cub;
      c.c2 = quad;
      c.c1 = times3(a2 - a0);
      c.c0 = a0 + (a1 <<< 2) + a2;
    end else begin
      c.c3 = times6(cub);
      c.c2 = times6(quad);
      c.c1 = ((a1 - a0) <<< 4) + ((a1 - a0) <<< 1);
      c.c0 = times6(a0);
    end
    return c;
  endfunction

  function automatic logic [AccW-1:0] accel_of(input coef_set_t c);
    logic [AccW-1:0] m2, m3;
    m2 = AccW'(c.c2[CoefW-1] ? -c.c2 : c.c2);
    m3 = AccW'(c.c3[CoefW-1] ? -c.c3 : c.c3);
    accel_of = (m2 << 1) + (m3 << 2) + (m3 << 1);
  endfunction

endpackage

// File: hw/rtl/cubic_curve_flattener_unit.sv
// Cubic curve flattener: control points in, a stream of Q14.4 curve points out.
//
// Input request (in_valid_i / in_ready_o): curve_mode_i (0 Bezier, 1 uniform
// B-spline segment) and four signed Q14.4 control points. in_ready_o is high
// only while the sequencer idles; one request is worked on at a time.
// Output request (out_valid_o / out_ready_i): one point per request, out_x_o,
// out_y_o, and last_point_o high on the endpoint at t = 1. Between 2 and
// MAX_RESULTS points come out per input request.
// Sequence: setup in S_COEF, S_ACCEL and S_DECIDE; when the acceleration bound
// exceeds 4 the step comes from a bit-serial divider and a 2-bit-per-cycle
// integer square root. For each point one shared 28x28 multiplier runs
// Horner's rule as two partial products per step (3 steps per coordinate)
// plus a reciprocal multiply for the final divide by 6, for x and then y.
// The output register holds a finished point while the next one is computed;
// a stalled receiver holds the sequencer only once that next point is ready.
// After the last point is registered the unit takes a new request at once.
// Reset clears the sequencer and the output valid; no point is pending.
module cubic_curve_flattener_unit #(
  parameter int MAX_RESULTS     = ccf_pkg::MaxResultsDef,
  parameter int COORD_FRAC_BITS = ccf_pkg::CoordFracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                curve_mode_i,
  input  logic signed [ccf_pkg::CoordW-1:0]   p0_x_i,
  input  logic signed [ccf_pkg::CoordW-1:0]   p0_y_i,
  input  logic signed [ccf_pkg::CoordW-1:0]   p1_x_i,
  input  logic signed [ccf_pkg::CoordW-1:0]   p1_y_i,
  input  logic signed [ccf_pkg::CoordW-1:0]   p2_x_i,
  input  logic signed [ccf_pkg::CoordW-1:0]   p2_y_i,
  input  logic signed [ccf_pkg::CoordW-1:0]   p3_x_i,
  input  logic signed [ccf_pkg::CoordW-1:0]   p3_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ccf_pkg::CoordW-1:0]   out_x_o,
  output logic signed [ccf_pkg::CoordW-1:0]   out_y_o,
  output logic                                last_point_o
);
  import ccf_pkg::*;

  // Step divider works on 24 * 2^(COORD_FRAC_BITS+32) / M.
  localparam int NW      = COORD_FRAC_BITS + 37;
  localparam int QW      = NW + (NW % 2);
  localparam int DCW     = $clog2(NW);
  localparam int NCW     = $clog2(MAX_RESULTS);
  localparam int MinStep = (TOne + MAX_RESULTS - 2) / (MAX_RESULTS - 1);
  localparam logic [NW-1:0]   DivNum    = {5'd24, {(COORD_FRAC_BITS + 32){1'b0}}};
  localparam logic [AccW-1:0] AccelThr  = AccW'(24 << COORD_FRAC_BITS);
  localparam logic [TW-1:0]   StepFull  = TW'(TOne);
  localparam logic [TW-1:0]   StepMin   = TW'(MinStep);
  localparam logic [NCW-1:0]  LastInner = NCW'(MAX_RESULTS - 2);
  localparam logic signed [QuotW-1:0] QuotOff = QuotW'(1 << 24);
  localparam logic signed [QuotW-1:0] SatLo   = -QuotW'(131072);
  localparam logic signed [QuotW-1:0] SatHi   = QuotW'(131071);

  ccf_state_e state_q, state_d;

  // latched request
  logic                     mode_q, mode_d;
  logic signed [CoordW-1:0] px_q [4];
  logic signed [CoordW-1:0] px_d [4];
  logic signed [CoordW-1:0] py_q [4];
  logic signed [CoordW-1:0] py_d [4];

  coef_set_t cx_q, cx_d, cy_q, cy_d;
  logic [AccW-1:0] m_q, m_d;

  // divider and square root
  logic [AccW:0]   rem_q, rem_d;
  logic [NW-1:0]   num_q, num_d, quot_q, quot_d;
  logic [DCW-1:0]  dcnt_q, dcnt_d;
  logic [QW-1:0]   sv_q, sv_d, sres_q, sres_d, sbit_q, sbit_d;

  // point sequencing
  logic [TW-1:0]   step_q, step_d, t_q, t_d;
  logic [NCW-1:0]  n_q, n_d;
  logic            sel_y_q, sel_y_d;
  logic [1:0]      k_q, k_d;
  logic signed [SumW-1:0]    s_q, s_d;
  logic signed [HornerW-1:0] acc_q, acc_d;
  logic [QuotW-1:0]          u_q, u_d;
  logic [QuotW-2:0]          dq_q, dq_d;
  logic signed [CoordW-1:0]  ox_q, ox_d;
  logic signed [CoordW-1:0]  oy_q, oy_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic signed [CoordW-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic                     out_last_q, out_last_d;

  // shared multiplier
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // control decode
  logic in_fire, out_load, div_last, sqrt_last, more_pts;
  logic [TW:0] t_next;
  coef_set_t   cur;
  logic signed [CoefW-1:0] ck;
  logic signed [21:0]      s_hi;
  logic [AccW:0]           trial;
  logic [QW-1:0]           sqrt_sum, sres_new;
  logic signed [QuotW-1:0] r_val;
  logic signed [CoordW-1:0] r_sat;

  assign t_next   = {1'b0, t_q} + {1'b0, step_q};
  assign more_pts = !t_next[TW] && !t_next[TW-1] && (n_q != LastInner);
  assign cur      = sel_y_q ? cy_q : cx_q;
  assign s_hi     = s_q[SumW-1:22];
  assign trial    = {rem_q[AccW-1:0], num_q[NW-1]};
  assign sqrt_sum = sres_q + sbit_q;
  assign sres_new = (sv_q >= sqrt_sum) ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
  assign r_val    = $signed({1'b0, dq_q}) - QuotOff;

  always_comb begin
    case (k_q)
      2'd2:    ck = cur.c2;
      2'd1:    ck = cur.c1;
      2'd0:    ck = cur.c0;
      default: ck = cur.c3;
    endcase
  end

  always_comb begin
    if (r_val < SatLo) begin
      r_sat = CoordW'(SatLo);
    end else if (r_val > SatHi) begin
      r_sat = CoordW'(SatHi);
    end else begin
      r_sat = CoordW'(r_val);
    end
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    in_fire    = in_valid_i && in_ready_o;
    out_load   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
    div_last   = (state_q == S_DIV) && (dcnt_q == '0);
    sqrt_last  = (state_q == S_SQRT) && sbit_q[0];
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      S_HLO: begin
        mul_a = {6'b0, s_q[21:0]};
        mul_b = MulW'(t_q);
      end
      S_HHI: begin
        mul_a = MulW'(s_hi);
        mul_b = MulW'(t_q);
      end
      S_DIV3: begin
        mul_a = {1'b0, u_q};
        mul_b = MulW'(Div3Mag);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = S_COEF;
      S_COEF:   state_d = S_ACCEL;
      S_ACCEL:  state_d = S_DECIDE;
      S_DECIDE: state_d = (m_q > AccelThr) ? S_DIV : S_HLO;
      S_DIV:    if (div_last) state_d = S_SQRT;
      S_SQRT:   if (sqrt_last) state_d = S_HLO;
      S_HLO:    state_d = S_HHI;
      S_HHI:    state_d = (k_q == 2'd0) ? S_RND : S_HLO;
      S_RND:    state_d = S_DIV3;
      S_DIV3:   state_d = S_SAT;
      S_SAT:    state_d = sel_y_q ? S_EMIT : S_HLO;
      S_EMIT: begin
        if (out_load) state_d = t_q[TW-1] ? S_IDLE : S_HLO;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mode_d      = mode_q;
    px_d        = px_q;
    py_d        = py_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    m_d         = m_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quot_d      = quot_q;
    dcnt_d      = dcnt_q;
    sv_d        = sv_q;
    sres_d      = sres_q;
    sbit_d      = sbit_q;
    step_d      = step_q;
    t_d         = t_q;
    n_d         = n_q;
    sel_y_d     = sel_y_q;
    k_d         = k_q;
    s_d         = s_q;
    acc_d       = acc_q;
    u_d         = u_q;
    dq_d        = dq_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d = curve_mode_i;
          px_d   = '{p0_x_i, p1_x_i, p2_x_i, p3_x_i};
          py_d   = '{p0_y_i, p1_y_i, p2_y_i, p3_y_i};
        end
      end
      S_COEF: begin
        cx_d = make_coefs(mode_q, px_q[0], px_q[1], px_q[2], px_q[3]);
        cy_d = make_coefs(mode_q, py_q[0], py_q[1], py_q[2], py_q[3]);
      end
      S_ACCEL: begin
        m_d = (accel_of(cx_q) > accel_of(cy_q)) ? accel_of(cx_q) : accel_of(cy_q);
      end
      S_DECIDE: begin
        t_d     = '0;
        n_d     = '0;
        sel_y_d = 1'b0;
        k_d     = 2'd2;
        s_d     = SumW'(cx_q.c3) <<< 16;
        step_d  = StepFull;
        rem_d   = '0;
        num_d   = DivNum;
        quot_d  = '0;
        dcnt_d  = DCW'(NW - 1);
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, m_q}) begin
          rem_d  = trial - {1'b0, m_q};
          quot_d = {quot_q[NW-2:0], 1'b1};
        end else begin
          rem_d  = trial;
          quot_d = {quot_q[NW-2:0], 1'b0};
        end
        num_d  = num_q << 1;
        dcnt_d = dcnt_q - 1'b1;
        sv_d   = QW'(quot_d);
        sres_d = '0;
        sbit_d = QW'(1) << (QW - 2);
      end
      S_SQRT: begin
        if (sv_q >= sqrt_sum) sv_d = sv_q - sqrt_sum;
        sres_d = sres_new;
        sbit_d = sbit_q >> 2;
        step_d = (sres_new < QW'(MinStep)) ? StepMin : sres_new[TW-1:0];
      end
      S_HLO: begin
        acc_d = HornerW'(mul_p);
      end
      S_HHI: begin
        acc_d = acc_q + (HornerW'(mul_p) <<< 22);
        s_d   = (SumW'(ck) <<< 16) + SumW'(acc_d >>> 16);
        k_d   = k_q - 1'b1;
      end
      S_RND: begin
        // floor((s + 3*2^16) / 2^17), biased positive for the divide by 3
        u_d = QuotW'(((s_q + SumW'(196608)) >>> 17) + SumW'(Div3Bias));
      end
      S_DIV3: begin
        dq_d = mul_p[52:27];
      end
      S_SAT: begin
        if (!sel_y_q) begin
          ox_d    = r_sat;
          sel_y_d = 1'b1;
          k_d     = 2'd2;
          s_d     = SumW'(cy_q.c3) <<< 16;
        end else begin
          oy_d = r_sat;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_x_d     = ox_q;
          out_y_d     = oy_q;
          out_last_d  = t_q[TW-1];
          n_d         = n_q + 1'b1;
          t_d         = more_pts ? t_next[TW-1:0] : StepFull;
          sel_y_d     = 1'b0;
          k_d         = 2'd2;
          s_d         = SumW'(cx_q.c3) <<< 16;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    px_q       <= px_d;
    py_q       <= py_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    m_q        <= m_d;
    rem_q      <= rem_d;
    num_q      <= num_d;
    quot_q     <= quot_d;
    dcnt_q     <= dcnt_d;
    sv_q       <= sv_d;
    sres_q     <= sres_d;
    sbit_q     <= sbit_d;
    step_q     <= step_d;
    t_q        <= t_d;
    n_q        <= n_d;
    sel_y_q    <= sel_y_d;
    k_q        <= k_d;
    s_q        <= s_d;
    acc_q      <= acc_d;
    u_q        <= u_d;
    dq_q       <= dq_d;
    ox_q       <= ox_d;
    oy_q       <= oy_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign last_point_o = out_last_q;

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HLO) |-> (step_q != '0))
    else $error("zero parameter step in point loop");

  a_t_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && t_q[TW-1]) |-> (t_q[TW-2:0] == '0))
    else $error("t beyond one");

  a_inner_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !t_q[TW-1]) |-> (n_q <= LastInner))
    else $error("too many interior points");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && t_q[TW-1]) |=> (state_q == S_IDLE && out_valid_q && out_last_q))
    else $error("endpoint did not close the request");

endmodule
